// File: rtl/wrs_pkg.sv
package wrs_pkg;

  // Block geometry, fixed by the field widths of the channels
  localparam int unsigned WARPS            = 4;
  localparam int unsigned WARP_BITS        = 2;
  localparam int unsigned REASON_BITS      = 3;
  localparam int unsigned BLOCK_FIELD_BITS = 16;
  localparam int unsigned EVENT_BITS       = 4;
  localparam int unsigned TAKEN_BITS       = 2;
  localparam int unsigned COUNT_BITS       = 3;
  localparam int unsigned ARRIVAL_BITS     = $clog2(WARPS + 1);

  // Event flag positions
  localparam int unsigned EV_LAUNCH  = 0;
  localparam int unsigned EV_FRONT   = 1;
  localparam int unsigned EV_MEMORY  = 2;
  localparam int unsigned EV_BARRIER = 3;

  // Take flag positions
  localparam int unsigned TAKE_GRANT  = 0;
  localparam int unsigned TAKE_FINISH = 1;

  // Stall reason codes
  localparam logic [REASON_BITS-1:0] REASON_NONE = 3'd0;
  localparam logic [REASON_BITS-1:0] REASON_DONE = 3'd1;

  localparam logic [ARRIVAL_BITS-1:0] ALL_ARRIVED = ARRIVAL_BITS'(WARPS);
  localparam logic [WARP_BITS-1:0]    LAST_WARP   = WARP_BITS'(WARPS - 1);

  typedef struct packed {
    logic [EVENT_BITS-1:0]       event_mask;
    logic [BLOCK_FIELD_BITS-1:0] launch_block;
    logic [WARP_BITS-1:0]        front_warp;
    logic [REASON_BITS-1:0]      front_reason;
    logic [WARP_BITS-1:0]        memory_warp;
    logic [REASON_BITS-1:0]      memory_reason;
    logic [WARP_BITS-1:0]        barrier_warp;
    logic [TAKEN_BITS-1:0]       taken_mask;
    logic [WARPS-1:0]            ready_mask;
  } wrs_req_t;

  typedef struct packed {
    logic                        grant_valid;
    logic [WARP_BITS-1:0]        grant_target;
    logic                        finish_valid;
    logic [BLOCK_FIELD_BITS-1:0] finish_block;
    logic [COUNT_BITS-1:0]       accepted_count;
    logic                        block_active;
  } wrs_rsp_t;

  // Result of the round-robin search
  typedef struct packed {
    logic                 found;
    logic [WARP_BITS-1:0] warp;
  } wrs_pick_t;

endpackage

// File: rtl/wrs_stream_if.sv
interface wrs_req_if;
  import wrs_pkg::*;

  logic     valid;
  logic     ready;
  wrs_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wrs_rsp_if;
  import wrs_pkg::*;

  logic     valid;
  logic     ready;
  wrs_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/wrs_pick.sv
module wrs_pick (
  input  logic [wrs_pkg::WARPS-1:0]     eligible_i,
  input  logic [wrs_pkg::WARP_BITS-1:0] ptr_i,
  output wrs_pkg::wrs_pick_t            pick_o
);
  import wrs_pkg::*;

  // Rotating priority encoder: first eligible warp at or after the pointer
  always_comb begin
    logic [WARP_BITS:0]   sum;
    logic [WARP_BITS-1:0] idx;
    pick_o = '0;
    for (int unsigned i = 0; i < WARPS; i++) begin
      sum = {1'b0, ptr_i} + (WARP_BITS + 1)'(i);
      if (sum >= (WARP_BITS + 1)'(WARPS)) begin
        sum = sum - (WARP_BITS + 1)'(WARPS);
      end
      idx = sum[WARP_BITS-1:0];
      if (!pick_o.found && eligible_i[idx]) begin
        pick_o.found = 1'b1;
        pick_o.warp  = idx;
      end
    end
  end

endmodule

// File: rtl/warp_round_robin_scheduler.sv
// Channel  | Dir | Contents
// ---------+-----+-----------------------------------------------------------
// req_i    | in  | one scheduler tick: events, stall reports, take flags, ready
// rsp_o    | out | grant, block-done offer, consumed count, block activity
//
// One request is taken per cycle unless rsp_o stalls; its response appears the next cycle.
// All per-tick work is a single combinational pass between the scheduler state
// and the response register; the four-warp rotating search is the longest path.
// req_i.ready drops only while a response sits unconsumed on rsp_o.
// Reset clears all scheduler state and leaves no response pending.
module warp_round_robin_scheduler #(
  parameter int unsigned BLOCK_INDEX_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wrs_req_if.sink   req_i,
  wrs_rsp_if.source rsp_o
);
  import wrs_pkg::*;

  // Scheduler state
  logic                              active_q, active_d;
  logic [BLOCK_INDEX_BITS-1:0]       block_q, block_d;
  logic [WARPS-1:0][REASON_BITS-1:0] front_stall_q, front_stall_d;
  logic [WARPS-1:0][REASON_BITS-1:0] mem_stall_q, mem_stall_d;
  logic [WARPS-1:0]                  barrier_q, barrier_d;
  logic [WARPS-1:0]                  finished_q, finished_d;
  logic [ARRIVAL_BITS-1:0]           arrivals_q, arrivals_d;
  logic [WARP_BITS-1:0]              ptr_q, ptr_d;
  logic                              held_q, held_d;
  logic [WARP_BITS-1:0]              held_warp_q, held_warp_d;
  logic                              fin_offer_q, fin_offer_d;
  logic                              fin_sent_q, fin_sent_d;

  // Values after events and grant retirement
  logic                 held_mid;
  logic [WARP_BITS-1:0] held_warp_mid;
  logic                 fin_offer_mid;
  logic                 fin_sent_mid;
  logic                 active_mid;
  logic [COUNT_BITS-1:0] count;

  logic [WARPS-1:0] eligible;
  wrs_pick_t        pick;

  logic     req_fire;
  logic     rsp_valid_q, rsp_valid_d;
  wrs_rsp_t rsp_q, rsp_d;

  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;

  // Events, in order: launch, front-end report, load/store report, barrier
  always_comb begin
    active_mid    = active_q;
    block_d       = block_q;
    front_stall_d = front_stall_q;
    mem_stall_d   = mem_stall_q;
    barrier_d     = barrier_q;
    finished_d    = finished_q;
    arrivals_d    = arrivals_q;
    ptr_d         = ptr_q;
    held_mid      = held_q;
    held_warp_mid = held_warp_q;
    fin_sent_mid  = fin_sent_q;
    count         = '0;
    fin_offer_mid = fin_offer_q && !req_i.data.taken_mask[TAKE_FINISH];

    if (req_i.data.event_mask[EV_LAUNCH]) begin
      active_mid    = 1'b1;
      block_d       = BLOCK_INDEX_BITS'(req_i.data.launch_block);
      front_stall_d = '0;
      mem_stall_d   = '0;
      barrier_d     = '0;
      finished_d    = '0;
      arrivals_d    = '0;
      ptr_d         = '0;
      held_mid      = 1'b0;
      held_warp_mid = '0;
      fin_offer_mid = 1'b0;
      fin_sent_mid  = 1'b0;
      count         = count + 1'b1;
    end

    if (req_i.data.event_mask[EV_FRONT]) begin
      front_stall_d[req_i.data.front_warp] = req_i.data.front_reason;
      if (req_i.data.front_reason == REASON_DONE) begin
        finished_d[req_i.data.front_warp] = 1'b1;
      end
      count = count + 1'b1;
    end

    if (req_i.data.event_mask[EV_MEMORY]) begin
      mem_stall_d[req_i.data.memory_warp] = req_i.data.memory_reason;
      count = count + 1'b1;
    end

    // Barrier: count first arrivals only, release all once everyone is in
    if (req_i.data.event_mask[EV_BARRIER]) begin
      if (!barrier_d[req_i.data.barrier_warp]) begin
        barrier_d[req_i.data.barrier_warp] = 1'b1;
        arrivals_d = arrivals_d + 1'b1;
      end
      count = count + 1'b1;
      if (arrivals_d >= ALL_ARRIVED) begin
        barrier_d  = '0;
        arrivals_d = '0;
      end
    end

    // Retire a taken grant; pointer moves past the granted warp
    if (held_mid && req_i.data.taken_mask[TAKE_GRANT]) begin
      ptr_d         = (held_warp_mid == LAST_WARP) ? '0 : held_warp_mid + 1'b1;
      held_mid      = 1'b0;
      held_warp_mid = '0;
      count         = count + 1'b1;
    end
  end

  // Runnable and ready warps
  always_comb begin
    for (int unsigned w = 0; w < WARPS; w++) begin
      eligible[w] = active_mid && !finished_d[w] && !barrier_d[w] &&
                    front_stall_d[w] == REASON_NONE && mem_stall_d[w] == REASON_NONE &&
                    req_i.data.ready_mask[w];
    end
  end

  wrs_pick u_pick (
    .eligible_i (eligible),
    .ptr_i      (ptr_d),
    .pick_o     (pick)
  );

  // New grant and block-done handshake
  always_comb begin
    held_d      = held_mid;
    held_warp_d = held_warp_mid;
    active_d    = active_mid;
    fin_offer_d = fin_offer_mid;
    fin_sent_d  = fin_sent_mid;

    if (!held_mid && active_mid && pick.found) begin
      held_d      = 1'b1;
      held_warp_d = pick.warp;
    end

    if (active_mid) begin
      if ((&finished_d) && !fin_offer_d && !fin_sent_d) begin
        fin_offer_d = 1'b1;
        fin_sent_d  = 1'b1;
      end
      if (fin_sent_d && !fin_offer_d) begin
        fin_sent_d = 1'b0;
        active_d   = 1'b0;
      end
    end
  end

  // Response payload
  always_comb begin
    rsp_d.grant_valid    = held_d;
    rsp_d.grant_target   = held_d ? held_warp_d : '0;
    rsp_d.finish_valid   = fin_offer_d;
    rsp_d.finish_block   = fin_offer_d ? BLOCK_FIELD_BITS'(block_d) : '0;
    rsp_d.accepted_count = count;
    rsp_d.block_active   = active_d;
  end

  // Response valid: set on a new request, cleared once taken
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (req_fire) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      block_q       <= '0;
      front_stall_q <= '0;
      mem_stall_q   <= '0;
      barrier_q     <= '0;
      finished_q    <= '0;
      arrivals_q    <= '0;
      ptr_q         <= '0;
      held_q        <= 1'b0;
      held_warp_q   <= '0;
      fin_offer_q   <= 1'b0;
      fin_sent_q    <= 1'b0;
      rsp_valid_q   <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      if (req_fire) begin
        active_q      <= active_d;
        block_q       <= block_d;
        front_stall_q <= front_stall_d;
        mem_stall_q   <= mem_stall_d;
        barrier_q     <= barrier_d;
        finished_q    <= finished_d;
        arrivals_q    <= arrivals_d;
        ptr_q         <= ptr_d;
        held_q        <= held_d;
        held_warp_q   <= held_warp_d;
        fin_offer_q   <= fin_offer_d;
        fin_sent_q    <= fin_sent_d;
      end
    end
  end

  // Response register, payload only
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

endmodule

// File: rtl/wrs_checker.sv
module wrs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input wrs_pkg::wrs_rsp_t rsp_data_i
);
  import wrs_pkg::*;

  // A stalled response stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // A stalled response keeps its payload
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_data_i))
    else $error("response payload changed while stalled");

  // Every accepted request produces a response in the next cycle
  a_req_to_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> rsp_valid_i)
    else $error("accepted request gave no response");

  // With the response slot empty the block must take requests
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i |-> req_ready_i)
    else $error("request side stalled with no response pending");

  // A block-done offer is only made for an active block
  a_finish_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.finish_valid |-> rsp_data_i.block_active)
    else $error("block-done offered for an inactive block");

endmodule

bind warp_round_robin_scheduler wrs_checker u_wrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wrs_pkg::*;

  localparam int unsigned RANDOM_TICKS   = 1800;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_SHOWN      = 10;

  // Event and take bit masks
  localparam logic [EVENT_BITS-1:0] EVM_NONE    = '0;
  localparam logic [EVENT_BITS-1:0] EVM_LAUNCH  = EVENT_BITS'(1 << EV_LAUNCH);
  localparam logic [EVENT_BITS-1:0] EVM_FRONT   = EVENT_BITS'(1 << EV_FRONT);
  localparam logic [EVENT_BITS-1:0] EVM_MEMORY  = EVENT_BITS'(1 << EV_MEMORY);
  localparam logic [EVENT_BITS-1:0] EVM_BARRIER = EVENT_BITS'(1 << EV_BARRIER);
  localparam logic [TAKEN_BITS-1:0] TKM_NONE    = '0;
  localparam logic [TAKEN_BITS-1:0] TKM_GRANT   = TAKEN_BITS'(1 << TAKE_GRANT);
  localparam logic [TAKEN_BITS-1:0] TKM_FINISH  = TAKEN_BITS'(1 << TAKE_FINISH);
  localparam logic [REASON_BITS-1:0] STALL_MAX  = '1;
  localparam logic [WARPS-1:0]       RDY_ALL    = '1;

  typedef struct {
    wrs_req_t req;
    bit       typed;
    wrs_rsp_t rsp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  wrs_req_if req_if ();
  wrs_rsp_if rsp_if ();

  warp_round_robin_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Scheduler state as the checker tracks it
  logic                   sch_active;
  logic [15:0]            sch_block;
  logic [REASON_BITS-1:0] sch_front [WARPS];
  logic [REASON_BITS-1:0] sch_mem [WARPS];
  logic [WARPS-1:0]       sch_bar;
  logic [WARPS-1:0]       sch_done;
  int unsigned            sch_arrivals;
  logic [WARP_BITS-1:0]   sch_ptr;
  logic                   sch_held;
  logic [WARP_BITS-1:0]   sch_held_warp;
  logic                   sch_fin_offered;
  logic                   sch_fin_sent;

  wrs_rsp_t pending_rsp_q [$];
  dir_row_t dir_tab [$];

  int unsigned n_sent, n_checked, n_err;
  int unsigned n_launch, n_handback, n_release, n_retired;
  int unsigned quiet;
  int unsigned hold_ticket;
  int unsigned burst_left, burst_free;

  // Random stream planning
  logic             plan_live;
  logic [WARPS-1:0] plan_done;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic wrs_req_t mk_req(logic [EVENT_BITS-1:0] ev, logic [15:0] blk,
                                      logic [WARP_BITS-1:0] fw, logic [REASON_BITS-1:0] fr,
                                      logic [WARP_BITS-1:0] mw, logic [REASON_BITS-1:0] mr,
                                      logic [WARP_BITS-1:0] bw, logic [TAKEN_BITS-1:0] tk,
                                      logic [WARPS-1:0] rdy);
    wrs_req_t r;
    r.event_mask    = ev;
    r.launch_block  = blk;
    r.front_warp    = fw;
    r.front_reason  = fr;
    r.memory_warp   = mw;
    r.memory_reason = mr;
    r.barrier_warp  = bw;
    r.taken_mask    = tk;
    r.ready_mask    = rdy;
    return r;
  endfunction

  function automatic wrs_rsp_t mk_rsp(logic gv, logic [WARP_BITS-1:0] gt, logic fv,
                                      logic [15:0] fb, logic [COUNT_BITS-1:0] cnt,
                                      logic act);
    wrs_rsp_t o;
    o.grant_valid    = gv;
    o.grant_target   = gt;
    o.finish_valid   = fv;
    o.finish_block   = fb;
    o.accepted_count = cnt;
    o.block_active   = act;
    return o;
  endfunction

  // Per-warp state cleared by reset and by launch
  task automatic sched_clear_warps();
    for (int w = 0; w < WARPS; w++) begin
      sch_front[w] = REASON_NONE;
      sch_mem[w]   = REASON_NONE;
    end
    sch_bar         = '0;
    sch_done        = '0;
    sch_arrivals    = 0;
    sch_ptr         = '0;
    sch_held        = 1'b0;
    sch_held_warp   = '0;
    sch_fin_offered = 1'b0;
    sch_fin_sent    = 1'b0;
  endtask

  function automatic logic sch_can_run(int unsigned w);
    return sch_active && !sch_done[w] && !sch_bar[w] &&
           sch_front[w] == REASON_NONE && sch_mem[w] == REASON_NONE;
  endfunction

  // One scheduler tick: apply events, retire and search grant, block-done handshake
  task automatic sched_tick(input wrs_req_t r, output wrs_rsp_t o);
    int unsigned          n;
    logic                 found;
    logic [WARP_BITS-1:0] w;
    n = 0;
    if (r.taken_mask[TAKE_FINISH]) sch_fin_offered = 1'b0;
    if (r.event_mask[EV_LAUNCH]) begin
      sched_clear_warps();
      sch_active = 1'b1;
      sch_block  = r.launch_block;
      n++;
      n_launch++;
    end
    if (r.event_mask[EV_FRONT]) begin
      sch_front[r.front_warp] = r.front_reason;
      if (r.front_reason == REASON_DONE) sch_done[r.front_warp] = 1'b1;
      n++;
    end
    if (r.event_mask[EV_MEMORY]) begin
      sch_mem[r.memory_warp] = r.memory_reason;
      n++;
    end
    if (r.event_mask[EV_BARRIER]) begin
      if (!sch_bar[r.barrier_warp]) begin
        sch_bar[r.barrier_warp] = 1'b1;
        sch_arrivals++;
      end
      n++;
      if (sch_arrivals >= WARPS) begin
        sch_bar      = '0;
        sch_arrivals = 0;
        n_release++;
      end
    end

    // Retire the held grant and move the pointer past it
    if (sch_held && r.taken_mask[TAKE_GRANT]) begin
      sch_ptr       = (sch_held_warp == LAST_WARP) ? '0 : sch_held_warp + 1'b1;
      sch_held      = 1'b0;
      sch_held_warp = '0;
      n++;
      n_retired++;
    end
    if (!sch_held && sch_active) begin
      found = 1'b0;
      for (int i = 0; i < WARPS; i++) begin
        w = WARP_BITS'((sch_ptr + i) % WARPS);
        if (!found && sch_can_run(w) && r.ready_mask[w]) begin
          found         = 1'b1;
          sch_held      = 1'b1;
          sch_held_warp = w;
        end
      end
    end

    if (sch_active) begin
      if (&sch_done && !sch_fin_offered && !sch_fin_sent) begin
        sch_fin_offered = 1'b1;
        sch_fin_sent    = 1'b1;
      end
      if (sch_fin_sent && !sch_fin_offered) begin
        sch_fin_sent = 1'b0;
        sch_active   = 1'b0;
        n_handback++;
      end
    end

    o = mk_rsp(sch_held, sch_held ? sch_held_warp : '0, sch_fin_offered,
               sch_fin_offered ? sch_block : '0, COUNT_BITS'(n), sch_active);
  endtask

  // Random tick: mostly a block running to completion, with stray launches
  task automatic next_random_tick(output wrs_req_t r);
    logic [EVENT_BITS-1:0] ev;
    r = mk_req(EVM_NONE, 16'($urandom), WARP_BITS'($urandom), REASON_NONE,
               WARP_BITS'($urandom), REASON_NONE, WARP_BITS'($urandom), TKM_NONE,
               ($urandom_range(0, 3) == 0) ? WARPS'($urandom) : WARPS'($urandom | $urandom));
    r.taken_mask[TAKE_GRANT]  = ($urandom_range(0, 9) < 7);
    r.taken_mask[TAKE_FINISH] = 1'($urandom_range(0, 1));
    ev = EVM_NONE;
    if (!plan_live || (&plan_done && $urandom_range(0, 3) == 0) ||
        $urandom_range(0, 149) == 0) begin
      ev        = EVM_LAUNCH;
      plan_live = 1'b1;
      plan_done = '0;
      if ($urandom_range(0, 3) == 0) ev = ev | EVENT_BITS'($urandom);
    end else begin
      if ($urandom_range(0, 1) == 0) ev = ev | EVM_FRONT;
      if ($urandom_range(0, 9) < 3) ev = ev | EVM_MEMORY;
      if ($urandom_range(0, 3) == 0) ev = ev | EVM_BARRIER;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r.front_reason = REASON_DONE;
      4, 5, 6:    r.front_reason = REASON_NONE;
      default:    r.front_reason = REASON_BITS'($urandom_range(2, 7));
    endcase
    r.memory_reason = ($urandom_range(0, 9) < 6) ? REASON_NONE :
                      REASON_BITS'($urandom_range(1, 7));
    r.event_mask = ev;
    if (ev[EV_FRONT] && r.front_reason == REASON_DONE) plan_done[r.front_warp] = 1'b1;
  endtask

  // Offer one request and record its expected response once accepted
  task automatic send(input wrs_req_t r, input bit typed, input wrs_rsp_t want);
    wrs_rsp_t p;
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sched_tick(r, p);
    pending_rsp_q.push_back(typed ? want : p);
    n_sent++;
  endtask

  // Sender bursts with random gaps
  task automatic pace();
    if (burst_free > 0) begin
      burst_free--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // Directed table
  initial begin
    // idle after reset, take flags with nothing offered
    dir_tab.push_back('{mk_req(EVM_NONE, 16'h0000, 0, REASON_NONE, 0, REASON_NONE, 0,
                               TKM_GRANT | TKM_FINISH, RDY_ALL),
                       1'b1, mk_rsp(0, 0, 0, 16'h0000, 3'd0, 0)});
    // events with no active block
    dir_tab.push_back('{mk_req(EVM_FRONT | EVM_MEMORY | EVM_BARRIER, 16'h0000, 3, STALL_MAX,
                               2, STALL_MAX, 1, TKM_NONE, RDY_ALL),
                       1'b1, mk_rsp(0, 0, 0, 16'h0000, 3'd3, 0)});
    dir_tab.push_back('{mk_req(EVM_LAUNCH, 16'hFFFF, 0, REASON_NONE, 0, REASON_NONE, 0,
                               TKM_NONE, RDY_ALL),
                       1'b1, mk_rsp(1, 0, 0, 16'h0000, 3'd1, 1)});
    dir_tab.push_back('{mk_req(EVM_NONE, 16'h0000, 0, REASON_NONE, 0, REASON_NONE, 0,
                               TKM_GRANT, RDY_ALL), 1'b0, '0});
    // launch withdraws the held grant, nothing ready
    dir_tab.push_back('{mk_req(EVM_LAUNCH, 16'h1234, 0, REASON_NONE, 0, REASON_NONE, 0,
                               TKM_GRANT | TKM_FINISH, '0),
                       1'b1, mk_rsp(0, 0, 0, 16'h0000, 3'd1, 1)});
    dir_tab.push_back('{mk_req(EVM_NONE, 16'h0000, 0, REASON_NONE, 0, REASON_NONE, 0,
                               TKM_NONE, 4'b1000), 1'b0, '0});
    // all events at once; memory reason done is only a stall
    dir_tab.push_back('{mk_req(EVM_LAUNCH | EVM_FRONT | EVM_MEMORY | EVM_BARRIER, 16'h0000,
                               0, REASON_DONE, 1, REASON_DONE, 2, TKM_GRANT | TKM_FINISH,
                               RDY_ALL), 1'b0, '0});
    dir_tab.push_back('{mk_req(EVM_NONE, 16'h0000, 0, REASON_NONE, 0, REASON_NONE, 0,
                               TKM_GRANT, RDY_ALL), 1'b0, '0});
    // repeated barrier arrival
    dir_tab.push_back('{mk_req(EVM_BARRIER, 16'h0000, 0, REASON_NONE, 0, REASON_NONE, 2,
                               TKM_NONE, RDY_ALL), 1'b0, '0});
    dir_tab.push_back('{mk_req(EVM_FRONT | EVM_MEMORY, 16'h0000, 3, 3'd6, 1, REASON_NONE, 0,
                               TKM_GRANT, RDY_ALL), 1'b0, '0});
    dir_tab.push_back('{mk_req(EVM_BARRIER, 16'h0000, 0, REASON_NONE, 0, REASON_NONE, 0,
                               TKM_GRANT, RDY_ALL), 1'b0, '0});
    dir_tab.push_back('{mk_req(EVM_BARRIER, 16'h0000, 0, REASON_NONE, 0, REASON_NONE, 1,
                               TKM_NONE, RDY_ALL), 1'b0, '0});
    // last arrival releases the barrier
    dir_tab.push_back('{mk_req(EVM_BARRIER, 16'h0000, 0, REASON_NONE, 0, REASON_NONE, 3,
                               TKM_NONE, RDY_ALL), 1'b0, '0});
    dir_tab.push_back('{mk_req(EVM_FRONT, 16'h0000, 3, REASON_NONE, 0, REASON_NONE, 0,
                               TKM_GRANT, 4'b1010), 1'b0, '0});
    dir_tab.push_back('{mk_req(EVM_NONE, 16'h0000, 0, REASON_NONE, 0, REASON_NONE, 0,
                               TKM_GRANT, '0), 1'b0, '0});
    dir_tab.push_back('{mk_req(EVM_FRONT, 16'h0000, 1, REASON_DONE, 0, REASON_NONE, 0,
                               TKM_GRANT, RDY_ALL), 1'b0, '0});
    dir_tab.push_back('{mk_req(EVM_FRONT | EVM_MEMORY, 16'h0000, 2, REASON_DONE, 0, STALL_MAX,
                               0, TKM_NONE, RDY_ALL), 1'b0, '0});
    // last warp done: block-done offered and held
    dir_tab.push_back('{mk_req(EVM_FRONT, 16'h0000, 3, REASON_DONE, 0, REASON_NONE, 0,
                               TKM_NONE, RDY_ALL), 1'b0, '0});
    dir_tab.push_back('{mk_req(EVM_NONE, 16'h0000, 0, REASON_NONE, 0, REASON_NONE, 0,
                               TKM_GRANT, RDY_ALL), 1'b0, '0});
    // launch withdraws the pending block-done offer
    dir_tab.push_back('{mk_req(EVM_LAUNCH, 16'hFFFF, 0, REASON_NONE, 0, REASON_NONE, 0,
                               TKM_NONE, RDY_ALL), 1'b0, '0});
    for (int w = 0; w < WARPS; w++)
      dir_tab.push_back('{mk_req(EVM_FRONT, 16'h0000, WARP_BITS'(w), REASON_DONE, 0,
                                 REASON_NONE, 0, TKM_GRANT, RDY_ALL), 1'b0, '0});
    // take block-done, block handed back
    dir_tab.push_back('{mk_req(EVM_NONE, 16'h0000, 0, REASON_NONE, 0, REASON_NONE, 0,
                               TKM_FINISH, RDY_ALL), 1'b0, '0});
    dir_tab.push_back('{mk_req(EVM_FRONT | EVM_MEMORY | EVM_BARRIER, 16'hFFFF, 3, STALL_MAX,
                               3, STALL_MAX, 3, TKM_GRANT | TKM_FINISH, RDY_ALL), 1'b0, '0});
  end

  // Main request sequence
  initial begin
    wrs_req_t r;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    n_sent = 0; n_checked = 0; n_err = 0;
    n_launch = 0; n_handback = 0; n_release = 0; n_retired = 0;
    hold_ticket = 0; burst_left = 0; burst_free = 0;
    plan_live = 1'b0;
    plan_done = '0;
    sch_active = 1'b0;
    sch_block  = '0;
    sched_clear_warps();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);
      pace();
    end
    drain();

    for (int k = 0; k < RANDOM_TICKS; k++) begin
      // long receiver hold-off while requests keep coming
      if (k == 600) begin
        hold_ticket++;
        burst_free = 40;
      end
      // sender pauses until every response is back
      if (k == 1200) drain();
      next_random_tick(r);
      send(r, 1'b0, '0);
      pace();
    end

    drain();
    repeat (4) @(posedge clk_i);
    $display("Covered %0d scheduler ticks, %0d responses checked, %0d mismatches.",
             n_sent, n_checked, n_err);
    $display("Blocks launched %0d, handed back %0d; barrier releases %0d; grants taken %0d.",
             n_launch, n_handback, n_release, n_retired);
    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Response side stall pattern, with a long hold-off on demand
  initial begin
    int unsigned hold_seen, hold_left, pat_cyc;
    logic        rdy;
    rsp_if.ready = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    pat_cyc   = 0;
    forever begin
      @(posedge clk_i);
      pat_cyc++;
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case ((pat_cyc / 64) % 4)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = (pat_cyc % 3) != 0;
          default: rdy = $urandom_range(0, 3) != 0;
        endcase
      end
      rsp_if.ready <= rdy;
    end
  end

  // Response checker
  always @(posedge clk_i) begin : check_rsp
    wrs_rsp_t want;
    if (rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp_q.size() == 0) begin
        n_err++;
        if (n_err <= MAX_SHOWN)
          $display("%0t: response with none pending: %p", $realtime, rsp_if.data);
      end else begin
        want = pending_rsp_q.pop_front();
        n_checked++;
        if (rsp_if.data.grant_valid    !== want.grant_valid    ||
            rsp_if.data.grant_target   !== want.grant_target   ||
            rsp_if.data.finish_valid   !== want.finish_valid   ||
            rsp_if.data.finish_block   !== want.finish_block   ||
            rsp_if.data.accepted_count !== want.accepted_count ||
            rsp_if.data.block_active   !== want.block_active) begin
          n_err++;
          if (n_err <= MAX_SHOWN)
            $display({"%0t: response %0d mismatch: grant %b/%0d finish %b/%h count %0d",
                      " active %b, expected grant %b/%0d finish %b/%h count %0d active %b"},
                     $realtime, n_checked,
                     rsp_if.data.grant_valid, rsp_if.data.grant_target,
                     rsp_if.data.finish_valid, rsp_if.data.finish_block,
                     rsp_if.data.accepted_count, rsp_if.data.block_active,
                     want.grant_valid, want.grant_target, want.finish_valid,
                     want.finish_block, want.accepted_count, want.block_active);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", quiet);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial quiet = 0;

endmodule
